// File: src/ssc_pkg.sv
// Shared types and constants for the subgradient step size controller.
// Depends on nothing; every other file except ssc_req_if takes names from here by scope.
package ssc_pkg;

   // Register map: word index taken from paddr[2]
   localparam logic REG_WINDOW_PERIOD = 1'b0;
   localparam logic REG_INITIAL_STEP  = 1'b1;

   localparam int PERIOD_BITS = 16;
   localparam int STEP_BITS   = 31;

   // Step limits in unsigned Q1.30: 1e-6 rounded up, and 1.0
   localparam logic [STEP_BITS-1:0] STEP_MIN = 31'd1074;
   localparam logic [STEP_BITS-1:0] STEP_MAX = 31'd1073741824;

   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 16'd20;
   localparam logic [STEP_BITS-1:0]   STEP_RESET   = 31'd107374182;

   typedef struct packed {
      logic [PERIOD_BITS-1:0] window_period;
      logic [STEP_BITS-1:0]   initial_step;
   } cfg_type;

   // Reinitialise request raised by a register write, with the step to load
   typedef struct packed {
      logic                 reinit;
      logic [STEP_BITS-1:0] step_load;
   } init_type;

endpackage

// File: src/ssc_req_if.sv
// Input word channel: valid/ready handshake carrying one lower bound.
// Depends on nothing.
interface ssc_req_if #(
   parameter int BOUND_BITS = 48
);
   logic                         valid;
   logic                         ready;
   logic signed [BOUND_BITS-1:0] bound_sample;

   modport source (output valid, output bound_sample, input ready);
   modport sink   (input valid, input bound_sample, output ready);
endinterface

// File: src/ssc_rsp_if.sv
// Result word channel: valid/ready handshake carrying step size and window flag.
// Depends on ssc_pkg for the step width.
interface ssc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ssc_pkg::STEP_BITS-1:0] step_len;
   logic                          window_closed;

   modport source (output valid, output step_len, output window_closed, input ready);
   modport sink   (input valid, input step_len, input window_closed, output ready);
endinterface

// File: src/ssc_csr.sv
// APB-style register file: window period and initial step.
// Depends on ssc_pkg; raises a reinitialise request on every write.
module ssc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output ssc_pkg::cfg_type              cfg,
   output ssc_pkg::init_type             init
);
   logic [ssc_pkg::PERIOD_BITS-1:0] period_ff, period_in;
   logic [ssc_pkg::STEP_BITS-1:0]   step_ff, step_in;
   logic                            wr_en;
   logic                            reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign reg_index = paddr[2];

   always_comb begin
      period_in = period_ff;
      step_in   = step_ff;
      if (wr_en) begin
         unique case (reg_index)
            ssc_pkg::REG_WINDOW_PERIOD: period_in = pwdata[ssc_pkg::PERIOD_BITS-1:0];
            ssc_pkg::REG_INITIAL_STEP:  step_in   = pwdata[ssc_pkg::STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= ssc_pkg::PERIOD_RESET;
         step_ff   <= ssc_pkg::STEP_RESET;
      end else begin
         period_ff <= period_in;
         step_ff   <= step_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         ssc_pkg::REG_WINDOW_PERIOD: prdata = {16'd0, period_ff};
         ssc_pkg::REG_INITIAL_STEP:  prdata = {1'b0, step_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   assign cfg.window_period = period_ff;
   assign cfg.initial_step  = step_ff;
   assign init.reinit       = wr_en;
   assign init.step_load    = step_in;

endmodule

// File: src/ssc_window_eval.sv
// Combinational tracker and step update for one bound word.
// Depends on ssc_pkg; the caller holds the state registers.
module ssc_window_eval #(
   parameter int BOUND_BITS = 48
) (
   input  logic signed [BOUND_BITS-1:0]       sample,
   input  logic signed [BOUND_BITS-1:0]       min_cur,
   input  logic signed [BOUND_BITS-1:0]       max_cur,
   input  logic [ssc_pkg::PERIOD_BITS-1:0]    count_cur,
   input  logic [ssc_pkg::STEP_BITS-1:0]      step_cur,
   input  logic [ssc_pkg::PERIOD_BITS-1:0]    period,
   output logic signed [BOUND_BITS-1:0]       min_nxt,
   output logic signed [BOUND_BITS-1:0]       max_nxt,
   output logic [ssc_pkg::PERIOD_BITS-1:0]    count_nxt,
   output logic [ssc_pkg::STEP_BITS-1:0]      step_nxt,
   output logic                               closed
);
   localparam int W = BOUND_BITS + 10;
   localparam logic signed [BOUND_BITS-1:0] MIN_START = {1'b0, {(BOUND_BITS-1){1'b1}}};
   localparam logic signed [BOUND_BITS-1:0] MAX_START = {1'b1, {(BOUND_BITS-1){1'b0}}};

   logic signed [BOUND_BITS-1:0] lo, hi;
   logic [BOUND_BITS-1:0]        spread, mag;
   logic [W-1:0]                 spread_w, mag_w, spread_x1000, spread_x100;
   logic                         tight, loose, hi_zero;
   logic [31:0]                  grown, halved, cand;
   logic [ssc_pkg::STEP_BITS-1:0] clamped;

   assign lo = (sample < min_cur) ? sample : min_cur;
   assign hi = (sample > max_cur) ? sample : max_cur;

   assign spread = $unsigned(hi - lo);
   assign mag    = hi[BOUND_BITS-1] ? $unsigned(-hi) : $unsigned(hi);

   // Exact products by shift and add: 1000 = 1024-16-8, 100 = 128-32+4
   assign spread_w     = {10'd0, spread};
   assign mag_w        = {10'd0, mag};
   assign spread_x1000 = (spread_w << 10) - (spread_w << 4) - (spread_w << 3);
   assign spread_x100  = (spread_w << 7) - (spread_w << 5) + (spread_w << 2);
   assign tight        = spread_x1000 <= mag_w;
   assign loose        = spread_x100 > mag_w;
   assign hi_zero      = hi == '0;

   assign grown  = {1'b0, step_cur} + {2'd0, step_cur[ssc_pkg::STEP_BITS-1:1]};
   assign halved = {2'd0, step_cur[ssc_pkg::STEP_BITS-1:1]};

   always_comb begin
      priority if (hi_zero) begin
         cand = (spread != '0) ? halved : {1'b0, step_cur};
      end else if (tight) begin
         cand = grown;
      end else if (loose) begin
         cand = halved;
      end else begin
         cand = {1'b0, step_cur};
      end
   end

   always_comb begin
      priority if (cand < {1'b0, ssc_pkg::STEP_MIN}) begin
         clamped = ssc_pkg::STEP_MIN;
      end else if (cand > {1'b0, ssc_pkg::STEP_MAX}) begin
         clamped = ssc_pkg::STEP_MAX;
      end else begin
         clamped = cand[ssc_pkg::STEP_BITS-1:0];
      end
   end

   assign closed = count_cur <= 16'd1;

   always_comb begin
      if (closed) begin
         min_nxt   = MIN_START;
         max_nxt   = MAX_START;
         count_nxt = period;
         step_nxt  = clamped;
      end else begin
         min_nxt   = lo;
         max_nxt   = hi;
         count_nxt = count_cur - 16'd1;
         step_nxt  = step_cur;
      end
   end

endmodule

// File: src/subgradient_step_size_control.sv
// Top level of the subgradient step size controller: input register, state,
// result register. Depends on ssc_pkg, ssc_req_if, ssc_rsp_if, ssc_csr, ssc_window_eval.
//
//   channel   direction  handshake              word
//   req_if    in         valid/ready            bound_sample, signed Q31.16
//   rsp_if    out        valid/ready            step_len Q1.30, window_closed
//   csr       in/out     psel/penable, pready   window_period, initial_step
//
// Flow: one word per cycle sustained while rsp_if.ready is high; each word passes the input
//   register, then the result register; the tracker and step feedback are combinational.
// Reset: synchronous, active high; valid flags, trackers, countdown and step load at once.
// Stalls: a held result keeps the input register full; req_if.ready drops only
//   when both stages hold a word and rsp_if.ready is low.
// Register writes reinitialise trackers, countdown and step in the same cycle.
module subgradient_step_size_control #(
   parameter int BOUND_BITS = 48
) (
   input  logic        clock,
   input  logic        reset,
   ssc_req_if.sink     req_if,
   ssc_rsp_if.source   rsp_if,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam logic signed [BOUND_BITS-1:0] MIN_START = {1'b0, {(BOUND_BITS-1){1'b1}}};
   localparam logic signed [BOUND_BITS-1:0] MAX_START = {1'b1, {(BOUND_BITS-1){1'b0}}};

   ssc_pkg::cfg_type  cfg;
   ssc_pkg::init_type init;

   // input register
   logic                         in_valid_ff, in_valid_in;
   logic signed [BOUND_BITS-1:0] sample_ff;

   // window state
   logic signed [BOUND_BITS-1:0]    min_ff, min_in, max_ff, max_in;
   logic [ssc_pkg::PERIOD_BITS-1:0] count_ff, count_in;
   logic [ssc_pkg::STEP_BITS-1:0]   step_ff, step_in;

   // result register
   logic                          out_valid_ff, out_valid_in;
   logic [ssc_pkg::STEP_BITS-1:0] out_step_ff;
   logic                          out_closed_ff;

   logic signed [BOUND_BITS-1:0]    min_nxt, max_nxt;
   logic [ssc_pkg::PERIOD_BITS-1:0] count_nxt;
   logic [ssc_pkg::STEP_BITS-1:0]   step_nxt;
   logic                            closed;
   logic                            advance, take;

   ssc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .init    (init)
   );

   ssc_window_eval #(.BOUND_BITS(BOUND_BITS)) u_eval (
      .sample    (sample_ff),
      .min_cur   (min_ff),
      .max_cur   (max_ff),
      .count_cur (count_ff),
      .step_cur  (step_ff),
      .period    (cfg.window_period),
      .min_nxt   (min_nxt),
      .max_nxt   (max_nxt),
      .count_nxt (count_nxt),
      .step_nxt  (step_nxt),
      .closed    (closed)
   );

   // advance the held word into the result register when that slot frees
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_if.ready);

   always_comb begin
      min_in   = min_ff;
      max_in   = max_ff;
      count_in = count_ff;
      step_in  = step_ff;
      priority if (init.reinit) begin
         // drop the window and restart from the loaded step
         min_in   = MIN_START;
         max_in   = MAX_START;
         count_in = '0;
         step_in  = init.step_load;
      end else if (advance) begin
         min_in   = min_nxt;
         max_in   = max_nxt;
         count_in = count_nxt;
         step_in  = step_nxt;
      end else begin
         // hold
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         min_ff       <= MIN_START;
         max_ff       <= MAX_START;
         count_ff     <= '0;
         step_ff      <= ssc_pkg::STEP_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (take) begin
         sample_ff <= req_if.bound_sample;
      end
      if (advance) begin
         out_step_ff   <= step_nxt;
         out_closed_ff <= closed;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.step_len      = out_step_ff;
   assign rsp_if.window_closed = out_closed_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cfg.window_period)
      else $error("countdown beyond window period");

   a_closed_step_range: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_closed_ff) |->
         (out_step_ff >= ssc_pkg::STEP_MIN && out_step_ff <= ssc_pkg::STEP_MAX))
      else $error("closed window gave step outside limits");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced word missing from result register");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(sample_ff)))
      else $error("stalled input word lost or changed");

   a_tracker_order: assert property (@(posedge clock) disable iff (reset)
      (min_ff != MIN_START || max_ff != MAX_START) |-> (min_ff <= max_ff))
      else $error("window minimum above maximum");
`endif

endmodule
